FILE: hw/rtl/msv_pkg.sv
// Shared types, widths and codes for the mesh signed volume engine.
package msv_pkg;

  localparam int CORNER_W         = 10;
  localparam int COORD_W          = 16;
  localparam int STORE_LIMIT      = 2 ** CORNER_W;
  localparam int MAX_VERTICES_DEF = 1024;

  localparam int CROSS_W = 2 * COORD_W + 1;        // difference of two products
  localparam int PROD_W  = COORD_W + CROSS_W;      // shared multiplier result
  localparam int DET_W   = PROD_W + 1;             // sum of three dot terms
  localparam int SUM_W   = 61;
  localparam int OUT_W   = 58;

  localparam logic CMD_VERTEX   = 1'b0;
  localparam logic CMD_TRIANGLE = 1'b1;

  localparam logic [2:0] DIVISOR = 3'd6;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

endpackage

FILE: hw/rtl/mesh_signed_volume.sv
// Vertex items: written to the store, busy stays low. Triangle items: busy while the sequencer
// runs three store reads and nine passes through one 16x33 multiplier.
// Final triangle: busy on through the divide by six (four 16-bit digit steps and a latch
// of the result), then out_valid strobes for one cycle; the receiver cannot stall it.
// Synchronous active-low reset clears the sequencer and the running sum;
// the vertex store is not cleared and holds undefined data until written.
module mesh_signed_volume #(
  parameter int MAX_VERTICES = msv_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_command,
  input  logic [msv_pkg::CORNER_W-1:0]       in_vertex_slot,
  input  logic signed [msv_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [msv_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [msv_pkg::COORD_W-1:0] in_coord_z,
  input  logic [msv_pkg::CORNER_W-1:0]       in_corner_a,
  input  logic [msv_pkg::CORNER_W-1:0]       in_corner_b,
  input  logic [msv_pkg::CORNER_W-1:0]       in_corner_c,
  input  logic                               in_final_triangle,
  output logic                               out_valid,
  output logic [msv_pkg::OUT_W-1:0]          out_mesh_volume
);
  import msv_pkg::*;

  localparam int STORE_DEPTH = (MAX_VERTICES < STORE_LIMIT) ? MAX_VERTICES : STORE_LIMIT;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_ACC  = 5'b01000,
    S_DIV  = 5'b10000
  } state_t;

  // multiplier schedule: three cross-product pairs, then the dot product
  localparam logic [3:0] K_CX_HI = 4'd0, K_CX_LO = 4'd1;
  localparam logic [3:0] K_CY_HI = 4'd2, K_CY_LO = 4'd3;
  localparam logic [3:0] K_CZ_HI = 4'd4, K_CZ_LO = 4'd5;
  localparam logic [3:0] K_DOT_X = 4'd6, K_DOT_Y = 4'd7, K_DOT_Z = 4'd8;
  localparam logic [3:0] K_LAST_ISSUE = K_DOT_Z;
  localparam logic [3:0] K_MUL_END    = 4'd9;
  localparam logic [3:0] K_READ_END   = 4'd3;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] pk;

  logic [CORNER_W-1:0] cor_a_r, cor_b_r, cor_c_r;
  logic                final_r;

  vertex_t pa_r, pb_r, pc_r;
  vertex_t rd_data;
  logic    rd_en;
  logic [CORNER_W-1:0] rd_addr;
  logic       cap_en_r;
  logic [1:0] cap_sel_r;

  logic signed [COORD_W-1:0] op1;
  logic signed [CROSS_W-1:0] op2;
  logic signed [PROD_W-1:0]  prod_nxt, prod_r;
  logic signed [2*COORD_W-1:0] prod_lo;
  logic signed [2*COORD_W-1:0] tmp_r;
  logic signed [CROSS_W-1:0] cross_r [3];
  logic signed [DET_W-1:0]   det_r;

  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0]        sum_sat;
  logic [SUM_W-1:0]        mag;

  logic                    div_start;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quo;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_vol_r;

  logic accept;
  logic vtx_wr;

  assign accept = start && (state_r == S_IDLE);
  assign vtx_wr = accept && (in_command == CMD_VERTEX);
  assign busy   = (state_r != S_IDLE);

  msv_vstore #(
    .DEPTH (STORE_DEPTH)
  ) u_vstore (
    .clk     (clk),
    .wr_en   (vtx_wr),
    .wr_addr (in_vertex_slot),
    .wr_data ({in_coord_x, in_coord_y, in_coord_z}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  msv_div6 u_div6 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  // corner fetch
  always_comb begin
    rd_en   = (state_r == S_READ) && (cnt_r < K_READ_END);
    case (cnt_r[1:0])
      2'd0:    rd_addr = cor_a_r;
      2'd1:    rd_addr = cor_b_r;
      default: rd_addr = cor_c_r;
    endcase
  end

  // shared multiplier operand selection
  always_comb begin
    case (cnt_r)
      K_CX_HI: begin op1 = pb_r.y; op2 = CROSS_W'(pc_r.z); end
      K_CX_LO: begin op1 = pb_r.z; op2 = CROSS_W'(pc_r.y); end
      K_CY_HI: begin op1 = pb_r.z; op2 = CROSS_W'(pc_r.x); end
      K_CY_LO: begin op1 = pb_r.x; op2 = CROSS_W'(pc_r.z); end
      K_CZ_HI: begin op1 = pb_r.x; op2 = CROSS_W'(pc_r.y); end
      K_CZ_LO: begin op1 = pb_r.y; op2 = CROSS_W'(pc_r.x); end
      K_DOT_X: begin op1 = pa_r.x; op2 = cross_r[0]; end
      K_DOT_Y: begin op1 = pa_r.y; op2 = cross_r[1]; end
      K_DOT_Z: begin op1 = pa_r.z; op2 = cross_r[2]; end
      default: begin op1 = '0;     op2 = '0; end
    endcase
  end

  assign prod_nxt = op1 * op2;
  assign prod_lo  = $signed(prod_r[2*COORD_W-1:0]);
  assign pk       = cnt_r - 4'd1;

  // saturating accumulate and magnitude for the final divide
  always_comb begin
    sum_wide = (SUM_W+1)'(sum_r) + (SUM_W+1)'(det_r);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    mag = sum_sat[SUM_W-1] ? (~sum_sat + 1'b1) : sum_sat;
  end

  assign div_start = (state_r == S_ACC) && final_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_command == CMD_TRIANGLE)) begin
          state_nxt = S_READ;
          cnt_nxt   = '0;
        end
      end
      S_READ: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == K_READ_END) begin
          state_nxt = S_MUL;
          cnt_nxt   = '0;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == K_MUL_END) begin
          state_nxt = S_ACC;
          cnt_nxt   = '0;
        end
      end
      S_ACC: begin
        state_nxt = final_r ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cap_en_r    <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cap_en_r    <= rd_en;
      out_valid_r <= (state_r == S_DIV) && div_done;
      if (state_r == S_ACC) begin
        sum_r <= final_r ? '0 : $signed(sum_sat);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cor_a_r <= in_corner_a;
      cor_b_r <= in_corner_b;
      cor_c_r <= in_corner_c;
      final_r <= in_final_triangle;
    end
    cap_sel_r <= cnt_r[1:0];
    if (cap_en_r) begin
      case (cap_sel_r)
        2'd0:    pa_r <= rd_data;
        2'd1:    pb_r <= rd_data;
        default: pc_r <= rd_data;
      endcase
    end
    if ((state_r == S_MUL) && (cnt_r <= K_LAST_ISSUE)) begin
      prod_r <= prod_nxt;
    end
    if ((state_r == S_MUL) && (cnt_r != '0)) begin
      case (pk)
        K_CX_HI, K_CY_HI, K_CZ_HI: tmp_r <= prod_lo;
        K_CX_LO: cross_r[0] <= CROSS_W'(tmp_r) - CROSS_W'(prod_lo);
        K_CY_LO: cross_r[1] <= CROSS_W'(tmp_r) - CROSS_W'(prod_lo);
        K_CZ_LO: cross_r[2] <= CROSS_W'(tmp_r) - CROSS_W'(prod_lo);
        K_DOT_X: det_r <= DET_W'(prod_r);
        K_DOT_Y, K_DOT_Z: det_r <= det_r + DET_W'(prod_r);
        default: det_r <= det_r;
      endcase
    end
    if ((state_r == S_DIV) && div_done) begin
      out_vol_r <= (|div_quo[SUM_W-1:OUT_W]) ? {OUT_W{1'b1}} : div_quo[OUT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mesh_volume = out_vol_r;

`ifndef NO_ASSERTIONS
  a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DIV))
    else $error("result strobe without a finished divide");

  a_tri_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_TRIANGLE) |=> busy)
    else $error("triangle transaction did not start the sequencer");

  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sum_r == '0))
    else $error("running sum not cleared after the final triangle");

  a_vertex_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_VERTEX) |=> !busy)
    else $error("vertex transaction raised busy");
`endif

endmodule

FILE: hw/rtl/msv_vstore.sv
// Vertex store: single write port, single registered read port.
module msv_vstore #(
  parameter int DEPTH = msv_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [msv_pkg::CORNER_W-1:0]  wr_addr,
  input  msv_pkg::vertex_t              wr_data,
  input  logic                          rd_en,
  input  logic [msv_pkg::CORNER_W-1:0]  rd_addr,
  output msv_pkg::vertex_t              rd_data
);
  import msv_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  vertex_t mem [DEPTH];
  vertex_t rd_q_r;
  logic    rd_oor_r;

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_addr) < DEPTH)) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr[AW-1:0]];
      rd_oor_r <= (32'(rd_addr) >= DEPTH);
    end
  end

  // out-of-range corners read as the origin
  assign rd_data = rd_oor_r ? '0 : rd_q_r;

endmodule

FILE: hw/rtl/msv_div6.sv
// Divide by six in 16-bit digits: one reciprocal multiply per digit, four digit steps.
module msv_div6 (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [msv_pkg::SUM_W-1:0]  dividend,
  output logic                       done,
  output logic [msv_pkg::SUM_W-1:0]  quotient
);
  import msv_pkg::*;

  localparam int DIG_W   = 16;
  localparam int N_DIG   = (SUM_W + DIG_W - 1) / DIG_W;
  localparam int SRC_W   = N_DIG * DIG_W;
  localparam int VAL_W   = DIG_W + 3;            // remainder below six, then one digit
  localparam int SHIFT   = VAL_W + 3;
  localparam int PROD_W2 = SHIFT + DIG_W;        // digit value times reciprocal stays below 2^38
  localparam int RECIP_W = 20;
  localparam logic [RECIP_W-1:0] RECIP = 20'd699051;   // ceil(2^22 / 6)
  localparam int CNT_W   = 3;

  logic [SRC_W-1:0]   src_r, src_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [2:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [VAL_W-1:0]   val;
  logic [PROD_W2-1:0] prod;
  logic [DIG_W-1:0]   qdig;
  logic [VAL_W-1:0]   back;

  always_comb begin
    val      = {rem_r, src_r[SRC_W-1 -: DIG_W]};
    prod     = PROD_W2'(val) * PROD_W2'(RECIP);
    qdig     = prod[SHIFT +: DIG_W];
    back     = val - VAL_W'(qdig) * VAL_W'(DIVISOR);
    src_nxt  = src_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      src_nxt = SRC_W'(dividend);
      rem_nxt = '0;
      cnt_nxt = CNT_W'(N_DIG);
      run_nxt = 1'b1;
    end else if (run_r) begin
      src_nxt = {src_r[SRC_W-DIG_W-1:0], {DIG_W{1'b0}}};
      quo_nxt = {quo_r[SUM_W-DIG_W-1:0], qdig};
      rem_nxt = back[2:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: verif/tb_mesh_signed_volume.sv
// Self-checking testbench for mesh_signed_volume: directed cases and random meshes against a local volume predictor.
module tb_mesh_signed_volume;
  timeunit 1ns;
  timeprecision 1ps;

  import msv_pkg::*;

  localparam int     CLK_HALF      = 5;
  localparam int     RESET_LEN     = 6;
  localparam int     MAX_REPORTS   = 10;
  localparam int     PHASE_ITEMS   = 465;
  localparam int     DRAIN_LIMIT   = 5000;
  localparam int     TAIL_CYCLES   = 80;   // triangle sequencing plus the divide
  localparam int     IDLE_LOW_PCT  = 14;
  localparam int     IDLE_HIGH_PCT = 63;
  localparam longint SUM_HI        = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_LO        = -SUM_HI - 1;
  localparam longint VOL_HI        = (longint'(1) << OUT_W) - 1;

  typedef struct {
    logic                cmd;
    logic [CORNER_W-1:0] slot;
    vertex_t             pos;
    logic [CORNER_W-1:0] ca;
    logic [CORNER_W-1:0] cb;
    logic [CORNER_W-1:0] cc;
    logic                fin;
  } mesh_item_t;

  class volume_scoreboard;
    vertex_t          vertex_mem [STORE_LIMIT];
    longint           six_vol_sum;
    logic [OUT_W-1:0] volumes_due [$];
    int               mismatches;

    function new();
      six_vol_sum = 0;
      mismatches  = 0;
    endfunction

    // a . (b x c), exact, in Q.36 units
    function longint six_volume(vertex_t a, vertex_t b, vertex_t c);
      return longint'(a.x) * (longint'(b.y) * c.z - longint'(b.z) * c.y)
           + longint'(a.y) * (longint'(b.z) * c.x - longint'(b.x) * c.z)
           + longint'(a.z) * (longint'(b.x) * c.y - longint'(b.y) * c.x);
    endfunction

    function void note_item(mesh_item_t it);
      longint s;
      longint mag;
      if (it.cmd == CMD_VERTEX) begin
        vertex_mem[it.slot] = it.pos;
        return;
      end
      s = six_vol_sum + six_volume(vertex_mem[it.ca], vertex_mem[it.cb], vertex_mem[it.cc]);
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      six_vol_sum = s;
      if (!it.fin) return;
      mag = (s < 0) ? -s : s;
      mag = mag / longint'(DIVISOR);
      if (mag > VOL_HI) mag = VOL_HI;
      volumes_due.push_back(OUT_W'(mag));
      six_vol_sum = 0;
    endfunction

    function void check_volume(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (volumes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: volume %0d with none expected", $time, got);
        return;
      end
      want = volumes_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mesh_volume expected %0d got %0d", $time, want, got);
      end
    endfunction

    function void close();
      if (volumes_due.size() != 0) begin
        $display("%0d mesh volumes never arrived", volumes_due.size());
        mismatches += volumes_due.size();
      end
    endfunction
  endclass

  logic                clk               = 1'b0;
  logic                rst_n             = 1'b0;
  logic                start             = 1'b0;
  logic                busy;
  logic                in_command        = CMD_VERTEX;
  logic [CORNER_W-1:0] in_vertex_slot    = '0;
  logic [COORD_W-1:0]  in_coord_x        = '0;
  logic [COORD_W-1:0]  in_coord_y        = '0;
  logic [COORD_W-1:0]  in_coord_z        = '0;
  logic [CORNER_W-1:0] in_corner_a       = '0;
  logic [CORNER_W-1:0] in_corner_b       = '0;
  logic [CORNER_W-1:0] in_corner_c       = '0;
  logic                in_final_triangle = 1'b0;
  logic                out_valid;
  logic [OUT_W-1:0]    out_mesh_volume;

  volume_scoreboard sb = new();

  int idle_pct   = 0;
  int items_sent = 0;
  bit slot_loaded [STORE_LIMIT];
  int loaded_list [$];

  mesh_signed_volume u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_vertex_slot    (in_vertex_slot),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_coord_z        (in_coord_z),
    .in_corner_a       (in_corner_a),
    .in_corner_b       (in_corner_b),
    .in_corner_c       (in_corner_c),
    .in_final_triangle (in_final_triangle),
    .out_valid         (out_valid),
    .out_mesh_volume   (out_mesh_volume)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_volume(out_mesh_volume);
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(8192)) - 16'h1000;   // within +/-1.0
      default: return 16'($urandom);
    endcase
  endfunction

  // corners only ever name entries already written
  function automatic logic [CORNER_W-1:0] pick_corner();
    return CORNER_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
  endfunction

  task automatic push_item(input mesh_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start             <= 1'b1;
    in_command        <= it.cmd;
    in_vertex_slot    <= it.slot;
    in_coord_x        <= it.pos.x;
    in_coord_y        <= it.pos.y;
    in_coord_z        <= it.pos.z;
    in_corner_a       <= it.ca;
    in_corner_b       <= it.cb;
    in_corner_c       <= it.cc;
    in_final_triangle <= it.fin;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(it);
    items_sent++;
    if (it.cmd == CMD_VERTEX && !slot_loaded[it.slot]) begin
      slot_loaded[it.slot] = 1'b1;
      loaded_list.push_back(int'(it.slot));
    end
  endtask

  task automatic load_vertex(input logic [CORNER_W-1:0] slot,
                             input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z, input logic fin = 1'b0);
    mesh_item_t it;
    it.cmd  = CMD_VERTEX;
    it.slot = slot;
    it.pos  = '{x: x, y: y, z: z};
    it.ca   = CORNER_W'($urandom);
    it.cb   = CORNER_W'($urandom);
    it.cc   = CORNER_W'($urandom);
    it.fin  = fin;
    push_item(it);
  endtask

  task automatic add_triangle(input logic [CORNER_W-1:0] a, input logic [CORNER_W-1:0] b,
                              input logic [CORNER_W-1:0] c, input logic fin);
    mesh_item_t it;
    it.cmd  = CMD_TRIANGLE;
    it.slot = CORNER_W'($urandom);
    it.pos  = '{x: 16'($urandom), y: 16'($urandom), z: 16'($urandom)};
    it.ca   = a;
    it.cb   = b;
    it.cc   = c;
    it.fin  = fin;
    push_item(it);
  endtask

  // hold start low until every outstanding volume has come back or the wait limit runs out
  task automatic settle(input int limit);
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.volumes_due.size() != 0 && waited < limit);
  endtask

  task automatic random_mesh();
    int nv;
    int nt;
    nv = $urandom_range(6, 1);
    repeat (nv)
      load_vertex(CORNER_W'($urandom), rand_coord(), rand_coord(), rand_coord(),
                  1'($urandom_range(1)));
    nt = $urandom_range(12, 1);
    for (int t = 1; t <= nt; t++) begin
      if ($urandom_range(9) == 0)
        load_vertex(CORNER_W'($urandom), rand_coord(), rand_coord(), rand_coord());
      // occasionally no closing triangle or an early one, so sums run across meshes
      add_triangle(pick_corner(), pick_corner(), pick_corner(),
                   (t == nt) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
    end
  endtask

  initial begin
    int phase_start;
    int pcts [3];
    pcts = '{IDLE_LOW_PCT, IDLE_HIGH_PCT, 0};
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = pcts[0];
    // extremes, unit axes, and a vertex transaction carrying a stray final flag
    load_vertex(10'd0,    16'h8000, 16'h8000, 16'h8000, 1'b1);
    load_vertex(10'd1023, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    load_vertex(10'd1,    16'h1000, 16'h0000, 16'h0000);
    load_vertex(10'd2,    16'h0000, 16'h1000, 16'h0000);
    load_vertex(10'd3,    16'h0000, 16'h0000, 16'h1000);
    load_vertex(10'd4,    16'h8000, 16'h0000, 16'h0000);
    load_vertex(10'd5,    16'h0000, 16'h8000, 16'h0000);
    load_vertex(10'd6,    16'h0000, 16'h0000, 16'h8000);
    add_triangle(10'd1, 10'd2, 10'd3, 1'b1);
    add_triangle(10'd1, 10'd3, 10'd2, 1'b1);     // negative orientation
    add_triangle(10'd4, 10'd5, 10'd6, 1'b0);
    add_triangle(10'd4, 10'd6, 10'd5, 1'b0);     // cancels to zero
    add_triangle(10'd0, 10'd0, 10'd0, 1'b1);
    add_triangle(10'd4, 10'd5, 10'd6, 1'b0);
    add_triangle(10'd4, 10'd5, 10'd6, 1'b0);
    add_triangle(10'd4, 10'd5, 10'd6, 1'b1);     // largest magnitude
    add_triangle(10'd0, 10'd1023, 10'd1, 1'b1);
    add_triangle(10'd1023, 10'd1023, 10'd2, 1'b1);
    load_vertex(10'd1,    16'hF000, 16'h0008, 16'hFFFF);
    add_triangle(10'd1, 10'd2, 10'd3, 1'b1);
    settle(DRAIN_LIMIT);

    foreach (pcts[p]) begin
      idle_pct    = pcts[p];
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) random_mesh();
      settle(DRAIN_LIMIT);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    sb.close();
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
